### sv/bvs_pkg.sv
// Package for the bitmap video scanout block.
// Holds raster constants, field widths and the shared structs.
// Used by the input and output interfaces and all modules; depends on nothing.
package bvs_pkg;

  localparam int VramDepthDefault = 8192;
  localparam int AddrW            = 13;
  localparam int DataW            = 8;
  localparam int RowW             = 8;
  localparam int ColW             = 9;

  localparam logic [RowW-1:0] LineFirst = 8'h20;
  localparam logic [RowW-1:0] LineLast  = 8'hff;
  localparam logic [RowW-1:0] RowMirror = 8'hff;
  localparam logic [ColW-1:0] ColActive = 9'd256;
  localparam logic [ColW-1:0] ColLast   = 9'd259;
  localparam logic [ColW-1:0] ColMirror = 9'd261;
  localparam logic [2:0]      LoadPhase = 3'h4;

  localparam logic OpWrite = 1'b0;
  localparam logic OpTick  = 1'b1;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] column;
    logic            on;
    logic            valid;
    logic            line_end;
    logic            frame_end;
  } pix_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } mem_req_t;

endpackage

### sv/bvs_ifs.sv
// Channel interfaces of the bitmap video scanout block.
// Input items, result items and the configuration write channel.
// Depends on bvs_pkg.
interface bvs_in_if import bvs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [AddrW-1:0] ram_address;
  logic [DataW-1:0] ram_data;
  modport source (output valid, op, ram_address, ram_data, input ready);
  modport sink (input valid, op, ram_address, ram_data, output ready);
endinterface

interface bvs_out_if import bvs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RowW-1:0] pixel_row;
  logic [ColW-1:0] pixel_column;
  logic            pixel_on;
  logic            pixel_valid;
  logic            line_end;
  logic            frame_end;
  modport source (output valid, pixel_row, pixel_column, pixel_on, pixel_valid,
                  line_end, frame_end, input ready);
  modport sink (input valid, pixel_row, pixel_column, pixel_on, pixel_valid,
                line_end, frame_end, output ready);
endinterface

interface bvs_cfg_if ();
  logic valid;
  logic ready;
  logic flip;
  modport source (output valid, flip, input ready);
  modport sink (input valid, flip, output ready);
endinterface

### sv/bvs_vram.sv
// Video RAM of the bitmap video scanout block.
// Single port synchronous memory with a registered read.
// Depends on bvs_pkg.
module bvs_vram import bvs_pkg::*; #(
  parameter int Depth = VramDepthDefault
) (
  input  logic             clk_i,
  input  mem_req_t         req_i,
  output logic [DataW-1:0] rdata_o
);

  localparam int IdxW = $clog2(Depth);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr[IdxW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr[IdxW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/bvs_raster.sv
// Raster counters and pixel shift register of the bitmap video scanout block.
// Issues video RAM reads for shifter loads and forms each tick's pixel.
// Depends on bvs_pkg.
module bvs_raster import bvs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  logic             flip_i,
  input  logic [DataW-1:0] rdata_i,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  output pix_t             pix_o
);

  logic [RowW-1:0]  line_q, line_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [DataW-1:0] shift_q, shift_d;
  logic             pend_q, pend_d;
  logic [DataW-1:0] shift_eff;
  logic [ColW-1:0]  col_next;
  logic             load;

  // A pending load means the shifter value sits in the RAM read register.
  assign shift_eff = pend_q ? rdata_i : shift_q;
  assign col_next  = col_q + 9'd1;
  assign load      = (col_q < ColActive) && (col_next < ColActive)
                     && (col_next[2:0] == LoadPhase);

  assign rd_en_o   = tick_i && load;
  assign rd_addr_o = {line_q, col_next[7:3]};

  always_comb begin
    pix_o.on        = shift_eff[0];
    pix_o.valid     = 1'b1;
    pix_o.row       = flip_i ? RowMirror - line_q : line_q - LineFirst;
    pix_o.column    = flip_i ? ColMirror - col_q : col_q;
    pix_o.line_end  = (col_q >= ColLast);
    pix_o.frame_end = (col_q >= ColLast) && (line_q >= LineLast);
  end

  always_comb begin
    line_d  = line_q;
    col_d   = col_q;
    shift_d = shift_q;
    pend_d  = pend_q;
    if (tick_i) begin
      shift_d = {1'b0, shift_eff[DataW-1:1]};
      pend_d  = load;
      if (col_q < ColLast) begin
        col_d = col_next;
      end else begin
        col_d = '0;
        if (line_q >= LineLast) begin
          line_d  = LineFirst;
          shift_d = '0;
          pend_d  = 1'b0;
        end else begin
          line_d = line_q + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= LineFirst;
      col_q   <= '0;
      shift_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      line_q  <= line_d;
      col_q   <= col_d;
      shift_q <= shift_d;
      pend_q  <= pend_d;
    end
  end

endmodule

### sv/bitmap_video_scanout.sv
// Bitmap video scanout: one bit per pixel video RAM shown through a shifter.
// An accepted item's result is registered in the output register.
// Throughput: one item per cycle while the output is not stalled, set by the single
// video RAM port; write and tick items may follow each other in every cycle.
// Reset: line 32, column 0, shifter clear, flip clear; video RAM is not cleared.
// Depends on bvs_pkg, bvs_ifs, bvs_vram and bvs_raster.
module bitmap_video_scanout import bvs_pkg::*; #(
  parameter int VRAM_DEPTH = VramDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  bvs_in_if.sink     in_i,
  bvs_cfg_if.sink    cfg_i,
  bvs_out_if.source  out_o
);

  logic             flip_q;
  logic             accept;
  logic             tick;
  logic             out_valid_q;
  pix_t             out_pix_q, out_pix_d;
  pix_t             raster_pix;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [DataW-1:0] rdata;
  mem_req_t         mem_req;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign tick        = accept && (in_i.op == OpTick);

  always_comb begin
    mem_req.we    = accept && (in_i.op == OpWrite);
    mem_req.re    = rd_en;
    mem_req.addr  = mem_req.we ? in_i.ram_address : rd_addr;
    mem_req.wdata = in_i.ram_data;
  end

  bvs_vram #(.Depth(VRAM_DEPTH)) u_vram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  bvs_raster u_raster (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .flip_i    (flip_q),
    .rdata_i   (rdata),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .pix_o     (raster_pix)
  );

  assign out_pix_d = (in_i.op == OpTick) ? raster_pix : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        flip_q <= cfg_i.flip;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_pix_q <= out_pix_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_row    = out_pix_q.row;
  assign out_o.pixel_column = out_pix_q.column;
  assign out_o.pixel_on     = out_pix_q.on;
  assign out_o.pixel_valid  = out_pix_q.valid;
  assign out_o.line_end     = out_pix_q.line_end;
  assign out_o.frame_end    = out_pix_q.frame_end;

  a_frame_implies_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_pix_q.frame_end |-> out_pix_q.line_end && out_pix_q.valid)
    else $error("frame end without line end");

  a_write_result_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_pix_q.valid |-> !out_pix_q.on && !out_pix_q.line_end)
    else $error("write result carries pixel data");

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !accept)
    else $error("item accepted while result stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item produced no result");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for bitmap_video_scanout: predicts the raster and checks each result transfer.
// Mixes video RAM writes and pixel ticks under both flip settings, with gaps and a long stall.
// Depends on bvs_pkg, bvs_ifs and the block's RTL.
module tb;
  import bvs_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned ErrorPrints = 40;

  typedef struct packed {
    logic             op;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } scan_item_t;

  logic clk_i;
  logic rst_ni;

  bvs_in_if  in_if ();
  bvs_cfg_if cfg_if ();
  bvs_out_if out_if ();

  bitmap_video_scanout i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  scan_item_t pending_items[$];
  pix_t       pix_expect[$];

  logic [DataW-1:0] vram_img[VramDepthDefault];
  logic [RowW-1:0]  line_q;
  logic [ColW-1:0]  column_q;
  logic [DataW-1:0] shifter_q;
  logic             flip_q;

  logic [RowW-1:0]  gen_line;
  logic [ColW-1:0]  gen_column;
  bit               vram_set[VramDepthDefault];

  int unsigned cycle_cnt    = 0;
  int unsigned idle_cycles  = 0;
  int unsigned results_seen = 0;
  int unsigned next_hold_at = 60;
  int unsigned fail_count   = 0;
  int unsigned in_gap       = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  logic        in_acc       = 1'b0;

  always #1 clk_i = ~clk_i;

  // Quiet windows give long stretches without random gaps on either side.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (cycle_cnt[10:9] == 2'b11) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic scan_step(input scan_item_t it, output pix_t px);
    logic [ColW-1:0] nxt;
    px = '0;
    if (it.op == OpWrite) begin
      vram_img[it.addr] = it.data;
    end else begin
      px.valid = 1'b1;
      px.on    = shifter_q[0];
      if (flip_q) begin
        px.row    = RowMirror - line_q;
        px.column = ColMirror - column_q;
      end else begin
        px.row    = line_q - LineFirst;
        px.column = column_q;
      end
      shifter_q = shifter_q >> 1;
      if (column_q < ColActive) begin
        nxt = column_q + 1'b1;
        if (nxt < ColActive && nxt[2:0] == LoadPhase) begin
          shifter_q = vram_img[{line_q, nxt[7:3]}];
        end
        column_q = nxt;
      end else if (column_q < ColLast) begin
        column_q = column_q + 1'b1;
      end else begin
        px.line_end = 1'b1;
        column_q    = '0;
        if (line_q == LineLast) begin
          px.frame_end = 1'b1;
          line_q       = LineFirst;
          shifter_q    = '0;
        end else begin
          line_q = line_q + 1'b1;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      fail_count++;
      if (fail_count <= ErrorPrints) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      end
    end
  endtask

  task automatic queue_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    vram_set[addr] = 1'b1;
    pending_items.push_back('{op: OpWrite, addr: addr, data: data});
  endtask

  // A tick that would load a line byte never written gets a write of that byte first.
  task automatic queue_tick();
    logic [ColW-1:0]  nxt;
    logic [AddrW-1:0] addr;
    if (gen_column < ColActive) begin
      nxt  = gen_column + 1'b1;
      addr = {gen_line, nxt[7:3]};
      if (nxt < ColActive && nxt[2:0] == LoadPhase && !vram_set[addr]) begin
        queue_write(addr, DataW'($urandom));
      end
      gen_column = nxt;
    end else if (gen_column < ColLast) begin
      gen_column = gen_column + 1'b1;
    end else begin
      gen_column = '0;
      if (gen_line == LineLast) begin
        gen_line = LineFirst;
      end else begin
        gen_line = gen_line + 1'b1;
      end
    end
    pending_items.push_back('{op: OpTick, addr: AddrW'($urandom), data: DataW'($urandom)});
  endtask

  task automatic queue_random(input int unsigned count, input int unsigned write_odds);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(99) < write_odds) begin
        queue_write(AddrW'($urandom), DataW'($urandom));
      end else begin
        queue_tick();
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_if.valid || pix_expect.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_flip(input logic value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.flip  <= value;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    scan_item_t it;
    if (rst_ni && (in_acc || !in_if.valid)) begin
      if (in_gap != 0) begin
        in_if.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        in_if.valid       <= 1'b1;
        in_if.op          <= it.op;
        in_if.ram_address <= it.addr;
        in_if.ram_data    <= it.data;
        in_gap            <= pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // The long hold lets the block fill up while the sender keeps offering items.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      out_if.ready <= 1'b0;
      hold_left    <= HoldCycles;
      next_hold_at <= next_hold_at * 16;
    end else if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      stall_left   <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    pix_t px;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_ni) begin
      line_q    = LineFirst;
      column_q  = '0;
      shifter_q = '0;
      flip_q    = 1'b0;
      in_acc    <= 1'b0;
    end else begin
      in_acc <= in_if.valid && in_if.ready;
      if (cfg_if.valid && cfg_if.ready) begin
        flip_q = cfg_if.flip;
      end
      if (out_if.valid && out_if.ready) begin
        results_seen <= results_seen + 1;
        if (pix_expect.size() == 0) begin
          fail_count++;
          if (fail_count <= ErrorPrints) begin
            $error("result transfer with no pending expectation");
          end
        end else begin
          px = pix_expect.pop_front();
          check_field("pixel_row", 16'(px.row), 16'(out_if.pixel_row));
          check_field("pixel_column", 16'(px.column), 16'(out_if.pixel_column));
          check_field("pixel_on", 16'(px.on), 16'(out_if.pixel_on));
          check_field("pixel_valid", 16'(px.valid), 16'(out_if.pixel_valid));
          check_field("line_end", 16'(px.line_end), 16'(out_if.line_end));
          check_field("frame_end", 16'(px.frame_end), 16'(out_if.frame_end));
        end
      end
      if (in_if.valid && in_if.ready) begin
        scan_step('{op: in_if.op, addr: in_if.ram_address, data: in_if.ram_data}, px);
        pix_expect.push_back(px);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
        $display("[bitmap_video_scanout] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.op          = OpWrite;
    in_if.ram_address = '0;
    in_if.ram_data    = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.flip       = 1'b0;
    out_if.ready      = 1'b0;
    gen_line          = LineFirst;
    gen_column        = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_flip(1'b0);
    queue_write('0, 8'h00);
    queue_write('1, 8'hff);
    queue_write({LineFirst, 5'd0}, 8'hff);
    queue_write({LineFirst, 5'd1}, 8'h81);
    queue_write({LineFirst, 5'd2}, 8'h55);
    queue_write({LineFirst, 5'd3}, 8'haa);
    repeat (18) queue_tick();
    queue_random(120, 30);
    wait_idle();

    set_flip(1'b1);
    queue_random(120, 30);
    wait_idle();

    set_flip(1'b0);
    queue_random(120, 30);
    wait_idle();

    if (fail_count == 0) begin
      $display("[bitmap_video_scanout] OK");
    end else begin
      $display("[bitmap_video_scanout] ERROR");
    end
    $finish;
  end

endmodule
